/* rtl/core/mexp_pkg.sv */
// Package for the modular exponentiation block.
// Holds the sequencer state type and the status struct shared by the core and the top level.
// No dependencies.
package mexp_pkg;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_SQR    = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_FIN    = 5'b10000
  } mexp_state_t;

  // Status that the core reports to the top level.
  typedef struct packed {
    logic busy;
    logic res_valid;
    logic bad_modulus;
  } mexp_stat_t;

endpackage

/* rtl/core/mexp_addmod.sv */
// Shared modular step unit: computes (2*x + y*add_en + cin) mod m.
// Requires x, y < m, so the raw sum stays below 3*m. No package dependencies.
module mexp_addmod #(
  parameter int W = 32
) (
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic         add_en_i,
  input  logic         cin_i,
  input  logic [W-1:0] m_i,
  output logic [W-1:0] r_o
);

  logic [W+1:0] sum;
  logic [W+1:0] m1;
  logic [W+1:0] m2;
  logic [W+1:0] d1;
  logic [W+1:0] d2;

  assign m1  = {2'b00, m_i};
  assign m2  = {1'b0, m_i, 1'b0};
  assign sum = {1'b0, x_i, cin_i} + (add_en_i ? {2'b00, y_i} : '0);
  assign d1  = sum - m1;
  assign d2  = sum - m2;

  always_comb begin
    if (sum >= m2) begin
      r_o = d2[W-1:0];
    end else if (sum >= m1) begin
      r_o = d1[W-1:0];
    end else begin
      r_o = sum[W-1:0];
    end
  end

endmodule

/* rtl/core/mexp_core.sv */
// Sequencer and operand registers of the modular exponentiation block.
// Depends on mexp_pkg and drives one mexp_addmod instance for every arithmetic step.
module mexp_core #(
  parameter int VW = 32,
  parameter int EW = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic                take_i,
  input  logic [VW-1:0]       base_i,
  input  logic [VW-1:0]       modulus_i,
  input  logic [EW-1:0]       exponent_i,
  output mexp_pkg::mexp_stat_t stat_o,
  output logic [VW-1:0]       result_o
);

  localparam int CW  = $clog2(VW);
  localparam int ECW = $clog2(EW);

  mexp_pkg::mexp_state_t state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [ECW-1:0] ecnt_r, ecnt_nxt;
  logic [EW-1:0]  exp_r, exp_nxt;
  logic [VW-1:0]  base_r, base_nxt;
  logic [VW-1:0]  mod_r, mod_nxt;
  logic [VW-1:0]  mula_r, mula_nxt;
  logic [VW-1:0]  mulb_r, mulb_nxt;
  logic [VW-1:0]  prod_r, prod_nxt;
  logic [VW-1:0]  res_r, res_nxt;
  logic           bad_r, bad_nxt;

  logic           is_reduce;
  logic           is_mul;
  logic [VW-1:0]  step;

  assign is_reduce = (state_r == mexp_pkg::ST_REDUCE);
  assign is_mul    = (state_r == mexp_pkg::ST_SQR) || (state_r == mexp_pkg::ST_MUL);

  mexp_addmod #(.W(VW)) u_addmod (
    .x_i      (prod_r),
    .y_i      (mula_r),
    .add_en_i (is_mul & mulb_r[VW-1]),
    .cin_i    (is_reduce & base_r[VW-1]),
    .m_i      (mod_r),
    .r_o      (step)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ecnt_nxt  = ecnt_r;
    exp_nxt   = exp_r;
    base_nxt  = base_r;
    mod_nxt   = mod_r;
    mula_nxt  = mula_r;
    mulb_nxt  = mulb_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    bad_nxt   = bad_r;
    unique case (state_r) inside
      mexp_pkg::ST_IDLE: begin
        if (start_i) begin
          mod_nxt  = modulus_i;
          exp_nxt  = exponent_i;
          base_nxt = base_i;
          prod_nxt = '0;
          cnt_nxt  = CW'(VW - 1);
          ecnt_nxt = ECW'(EW - 1);
          res_nxt  = '0;
          bad_nxt  = (modulus_i == '0);
          if (modulus_i == '0 || modulus_i == VW'(1)) begin
            state_nxt = mexp_pkg::ST_FIN;
          end else begin
            state_nxt = mexp_pkg::ST_REDUCE;
          end
        end
      end
      mexp_pkg::ST_REDUCE: begin
        // Restoring remainder of the base, one base bit per cycle.
        prod_nxt = step;
        base_nxt = base_r << 1;
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          base_nxt  = step;
          mula_nxt  = VW'(1);
          mulb_nxt  = VW'(1);
          prod_nxt  = '0;
          cnt_nxt   = CW'(VW - 1);
          state_nxt = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_SQR, mexp_pkg::ST_MUL: begin
        // Shift-and-add modular product, one multiplier bit per cycle.
        prod_nxt = step;
        mulb_nxt = mulb_r << 1;
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          prod_nxt = '0;
          cnt_nxt  = CW'(VW - 1);
          if (state_r == mexp_pkg::ST_SQR && exp_r[EW-1]) begin
            mula_nxt  = step;
            mulb_nxt  = base_r;
            state_nxt = mexp_pkg::ST_MUL;
          end else if (ecnt_r == '0) begin
            res_nxt   = step;
            state_nxt = mexp_pkg::ST_FIN;
          end else begin
            ecnt_nxt  = ecnt_r - ECW'(1);
            exp_nxt   = exp_r << 1;
            mula_nxt  = step;
            mulb_nxt  = step;
            state_nxt = mexp_pkg::ST_SQR;
          end
        end
      end
      mexp_pkg::ST_FIN: begin
        if (take_i) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    ecnt_r <= ecnt_nxt;
    exp_r  <= exp_nxt;
    base_r <= base_nxt;
    mod_r  <= mod_nxt;
    mula_r <= mula_nxt;
    mulb_r <= mulb_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    bad_r  <= bad_nxt;
  end

  assign stat_o.busy        = (state_r != mexp_pkg::ST_IDLE);
  assign stat_o.res_valid   = (state_r == mexp_pkg::ST_FIN);
  assign stat_o.bad_modulus = bad_r;
  assign result_o           = res_r;

endmodule

/* rtl/core/modular_exponentiation.sv */
// Sequence: with a modulus of 0 or 1 the sequencer goes from idle straight to its finish state;
// else it reduces the base, then squares once per exponent bit and multiplies once per set bit.
// Throughput: one item at a time; the single modular add/compare unit does one bit step per
// cycle; the next transfer in waits until the core is idle again as the result register loads.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the output register.
// Top level of the modular exponentiation block; depends on mexp_pkg, mexp_core and mexp_addmod.
module modular_exponentiation #(
  parameter int VALUE_WIDTH = 32,
  parameter int EXP_WIDTH   = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_base,
  input  logic [VALUE_WIDTH-1:0] in_modulus,
  input  logic [EXP_WIDTH-1:0]   in_exponent,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_result,
  output logic                   out_bad_modulus
);

  // The core first reduces the base modulo the modulus with a restoring remainder, one base
  // bit per cycle. It then walks the exponent from its top bit down: every exponent bit costs
  // one modular squaring, and a set bit costs one more modular multiplication by the reduced
  // base. Each product is a shift-and-add over VALUE_WIDTH multiplier bits, where every cycle
  // doubles the partial product and conditionally adds the multiplicand, reduced by one
  // compare against the modulus and twice the modulus.

  mexp_pkg::mexp_stat_t      stat;
  logic [VALUE_WIDTH-1:0]    core_result;
  logic                      start;
  logic                      take;

  logic                      out_valid_r;
  logic [VALUE_WIDTH-1:0]    out_result_r;
  logic                      out_bad_r;

  // A new item is transferred in only while the core is idle.
  assign in_stall = stat.busy;
  assign start    = in_valid && !stat.busy;

  // The finished result moves into the output register whenever that register is empty or
  // is being emptied by a transfer in the same cycle.
  assign take = stat.res_valid && (!out_valid_r || !out_stall);

  mexp_core #(
    .VW (VALUE_WIDTH),
    .EW (EXP_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .take_i     (take),
    .base_i     (in_base),
    .modulus_i  (in_modulus),
    .exponent_i (in_exponent),
    .stat_o     (stat),
    .result_o   (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result_r <= core_result;
      out_bad_r    <= stat.bad_modulus;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_bad_modulus = out_bad_r;

endmodule

/* rtl/core/mexp_checker.sv */
// Port-level checker for the modular exponentiation block, bound to the top level.
// Depends only on the top-level ports; no package dependencies.
module mexp_checker #(
  parameter int VALUE_WIDTH = 32,
  parameter int EXP_WIDTH   = 64
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [VALUE_WIDTH-1:0] in_base,
  input logic [VALUE_WIDTH-1:0] in_modulus,
  input logic [EXP_WIDTH-1:0]   in_exponent,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [VALUE_WIDTH-1:0] out_result,
  input logic                   out_bad_modulus
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_base) && $stable(in_modulus) &&
                             $stable(in_exponent))
    else $error("stalled input changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not blocked after a transfer");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_modulus |-> out_result == '0)
    else $error("nonzero result with zero modulus");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("core still busy after handing over its result");

endmodule

bind modular_exponentiation mexp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH),
  .EXP_WIDTH   (EXP_WIDTH)
) u_mexp_checker (.*);
